>>> src/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// No dependencies; imported by lpht_store and linear_probe_hash_table_top.
package lpht_pkg;

    localparam int KEY_W     = 64;
    localparam int DATA_W    = 64;
    localparam int LIMIT_W   = 10;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [KEY_W-1:0]   EMPTY_KEY   = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd768;

    // Register index, taken from paddr[2]
    localparam logic REG_ENTRY_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        STAT_MISS     = 3'd0,
        STAT_HIT      = 3'd1,
        STAT_UPDATED  = 3'd2,
        STAT_INSERTED = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Write controls from the sequencer to the slot store
    typedef struct packed {
        logic clear;
        logic key_we;
        logic val_we;
    } t_mem_ctl;

endpackage

>>> src/lpht_store.sv
// Key and value slot memories: one address, registered read data.
// Depends on lpht_pkg.
module lpht_store #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 64
) (
    input  logic                                 i_clk,
    input  lpht_pkg::t_mem_ctl                   i_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_addr,
    input  logic [lpht_pkg::KEY_W-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]                i_val,
    output logic [lpht_pkg::KEY_W-1:0]           o_key,
    output logic [VALUE_BITS-1:0]                o_val
);
    import lpht_pkg::*;

    logic [KEY_W-1:0]      key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            key_mem[i_addr] <= i_ctl.clear ? EMPTY_KEY : i_key;
        end
        o_key <= key_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            val_mem[i_addr] <= i_val;
        end
        o_val <= val_mem[i_addr];
    end

endmodule

>>> src/linear_probe_hash_table_top.sv
// Linear-probe hash table: sequencer, config register and output word register.
// Depends on lpht_pkg and lpht_store.
//
// Usage:
//   Input words arrive on s_axis: tdata carries key and write_value, tuser
//   carries mode (0 get, 1 set). Each word yields one output word on m_axis:
//   tdata carries read_value, tuser carries status.
//   The probe starts at key modulo TABLE_DEPTH and walks forward one slot
//   at a time (memory read, then compare); the next word is accepted only
//   after the result of the last one has been loaded into the output
//   register. A reserved all-ones key skips the probe. The default entry
//   limit is 75 percent of the table. s_axis_tready is high only between
//   operations. The output register holds a finished word while m_axis_tready
//   is low; the next word may be accepted and probed meanwhile, and waits
//   before the output register until it frees.
//   After reset a clearing pass writes the empty key into every slot, one
//   slot per cycle, with s_axis_tready low; APB writes of entry_limit
//   (address 0) are taken at any time.
module linear_probe_hash_table_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpht_pkg::PADDR_W-1:0]      paddr,
    input  logic [lpht_pkg::PDATA_W-1:0]      pwdata,
    output logic [lpht_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // Input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*lpht_pkg::KEY_W-1:0]      s_axis_tdata,  // key[63:0], write_value[127:64]
    input  logic                              s_axis_tuser,  // mode[0]
    // Output words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lpht_pkg::DATA_W-1:0]       m_axis_tdata,  // read_value[63:0]
    output logic [2:0]                        m_axis_tuser   // status[2:0]
);
    import lpht_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_pcnt, n_pcnt;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [VALUE_BITS-1:0] r_wval, n_wval;
    logic                  r_mode, n_mode;
    logic [LIMIT_W-1:0]    r_limit;
    logic [CW-1:0]         r_count, n_count;
    t_status               r_res_status, n_res_status;
    logic [VALUE_BITS-1:0] r_res_val, n_res_val;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [VALUE_BITS-1:0] r_out_val, n_out_val;

    t_mem_ctl              mem_ctl;
    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  key_hit;
    logic                  key_empty;
    logic                  room_left;
    logic                  in_fire;
    logic                  out_free;
    logic                  cfg_write;

    lpht_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (r_addr),
        .i_key  (r_key),
        .i_val  (r_wval),
        .o_key  (rd_key),
        .o_val  (rd_val)
    );

    // Configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ENTRY_LIMIT) ? PDATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (cfg_write && paddr[2] == REG_ENTRY_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = DATA_W'(r_out_val);

    assign key_hit   = (rd_key == r_key);
    assign key_empty = (rd_key == EMPTY_KEY);
    assign room_left = CMP_W'(r_count) < CMP_W'(r_limit);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_pcnt       = r_pcnt;
        n_key        = r_key;
        n_wval       = r_wval;
        n_mode       = r_mode;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_val    = r_out_val;
        mem_ctl      = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                mem_ctl.clear  = 1'b1;
                mem_ctl.key_we = 1'b1;
                n_addr         = r_addr + 1'b1;
                if (r_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_key     = s_axis_tdata[KEY_W-1:0];
                    n_wval    = s_axis_tdata[KEY_W +: VALUE_BITS];
                    n_mode    = s_axis_tuser;
                    n_addr    = s_axis_tdata[AW-1:0];
                    n_pcnt    = '0;
                    n_res_val = '0;
                    if (s_axis_tdata[KEY_W-1:0] == EMPTY_KEY) begin
                        // reserved key never probes
                        n_res_status = s_axis_tuser ? STAT_FULL : STAT_MISS;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (key_hit) begin
                    if (r_mode) begin
                        mem_ctl.val_we = 1'b1;
                        n_res_status   = STAT_UPDATED;
                    end else begin
                        n_res_status = STAT_HIT;
                        n_res_val    = rd_val;
                    end
                    n_state = ST_DONE;
                end else if (key_empty) begin
                    if (!r_mode) begin
                        n_res_status = STAT_MISS;
                    end else if (room_left) begin
                        mem_ctl.key_we = 1'b1;
                        mem_ctl.val_we = 1'b1;
                        n_count        = r_count + 1'b1;
                        n_res_status   = STAT_INSERTED;
                    end else begin
                        n_res_status = STAT_FULL;
                    end
                    n_state = ST_DONE;
                end else if (r_pcnt == LAST_SLOT) begin
                    // walked the whole table without an empty slot
                    n_res_status = r_mode ? STAT_FULL : STAT_MISS;
                    n_state      = ST_DONE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_pcnt  = r_pcnt + 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_val    = r_res_val;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcnt       <= n_pcnt;
        r_key        <= n_key;
        r_wval       <= n_wval;
        r_mode       <= n_mode;
        r_res_status <= n_res_status;
        r_res_val    <= n_res_val;
        r_out_status <= n_out_status;
        r_out_val    <= n_out_val;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.key_we && !mem_ctl.clear) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance entry count");

    a_probe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && !key_hit && !key_empty && r_pcnt != LAST_SLOT)
        |=> (r_state == ST_READ && r_addr == $past(r_addr) + 1'b1))
        else $error("probe did not step to next slot");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

>>> dv/tb_linear_probe_hash_table_top.sv
// Testbench for linear_probe_hash_table_top: drives get/set words and APB writes
// of entry_limit, and checks every output word against a scoreboard that mirrors the table.
// Depends on lpht_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_top;
    import lpht_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int VALUE_BITS     = 64;
    localparam int SLOT_W         = $clog2(TABLE_DEPTH);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_PHASES     = 7;
    localparam int SHOW_LIMIT     = 10;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_ENTRY_LIMIT = {REG_ENTRY_LIMIT, 2'b00};
    localparam logic [DATA_W-1:0]  VALUE_MASK       = {DATA_W{1'b1}} >> (DATA_W - VALUE_BITS);

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] value;
    } t_answer;

    // Mirror of the slot store; predicts the answer of each accepted word
    class lookup_scoreboard;
        logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
        logic [DATA_W-1:0]  slot_value [TABLE_DEPTH];
        int unsigned        live_entries;
        logic [LIMIT_W-1:0] entry_limit;
        t_answer            answer_q [$];
        int                 fail_count;
        int                 results_seen;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_key[i]   = EMPTY_KEY;
                slot_value[i] = '0;
            end
            live_entries = 0;
            entry_limit  = LIMIT_RESET;
            fail_count   = 0;
            results_seen = 0;
        endfunction

        function void note_mismatch(string msg);
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display("%s", msg);
        endfunction

        function void note_request(logic mode, logic [KEY_W-1:0] key, logic [DATA_W-1:0] wval);
            t_answer     ans;
            int unsigned slot;
            bit          hit;
            bit          empty_seen;

            ans.status = STAT_MISS;
            ans.value  = '0;
            if (key == EMPTY_KEY) begin
                ans.status = (mode == MODE_SET) ? STAT_FULL : STAT_MISS;
            end else begin
                slot       = 32'(key % TABLE_DEPTH);
                hit        = 1'b0;
                empty_seen = 1'b0;
                for (int n = 0; n < TABLE_DEPTH && !hit && !empty_seen; n++) begin
                    if (slot_key[slot] == EMPTY_KEY)
                        empty_seen = 1'b1;
                    else if (slot_key[slot] == key)
                        hit = 1'b1;
                    else
                        slot = (slot + 1) % TABLE_DEPTH;
                end
                if (mode == MODE_GET) begin
                    if (hit) begin
                        ans.status = STAT_HIT;
                        ans.value  = slot_value[slot] & VALUE_MASK;
                    end
                end else if (hit) begin
                    slot_value[slot] = wval & VALUE_MASK;
                    ans.status       = STAT_UPDATED;
                end else if (!empty_seen || live_entries >= entry_limit) begin
                    ans.status = STAT_FULL;
                end else begin
                    slot_key[slot]   = key;
                    slot_value[slot] = wval & VALUE_MASK;
                    live_entries++;
                    ans.status = STAT_INSERTED;
                end
            end
            answer_q.push_back(ans);
        endfunction

        function void check_result(logic [2:0] status, logic [DATA_W-1:0] value);
            t_answer exp;
            results_seen++;
            if (answer_q.size() == 0) begin
                note_mismatch($sformatf("result %0d: unexpected word, status %0d value %h",
                                        results_seen, status, value));
                return;
            end
            exp = answer_q.pop_front();
            if (status !== exp.status)
                note_mismatch($sformatf("result %0d: status expected %0d got %0d",
                                        results_seen, exp.status, status));
            if (value !== exp.value)
                note_mismatch($sformatf("result %0d: read_value expected %h got %h",
                                        results_seen, exp.value, value));
        endfunction

        function int pending();
            return answer_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [2*KEY_W-1:0]     s_axis_tdata;   // key[63:0], write_value[127:64]
    logic                   s_axis_tuser;   // mode[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [DATA_W-1:0]      m_axis_tdata;   // read_value[63:0]
    logic [2:0]             m_axis_tuser;   // status[2:0]

    lookup_scoreboard       sb;
    logic [KEY_W-1:0]       key_pool [$];
    bit                     quiet;
    int                     idle_cycles;

    int unsigned phase_limit [NUM_PHASES] = '{1, 64, 150, 250, 360, 1023, 768};
    int unsigned phase_items [NUM_PHASES] = '{120, 200, 250, 280, 300, 320, 280};

    linear_probe_hash_table_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none while quiet
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        else if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(40, 150);
    endfunction

    function logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] key;
        int               r;
        r   = $urandom_range(0, 99);
        key = {$urandom, $urandom};
        // pile keys onto the slots around the wrap point, or set the upper key bits all ones
        if (r < 15)
            key[SLOT_W-1:0] = SLOT_W'((TABLE_DEPTH - 8 + $urandom_range(0, 15)) % TABLE_DEPTH);
        else if (r < 20)
            key[KEY_W-1:SLOT_W] = '1;
        if (key == EMPTY_KEY)
            key[0] = 1'b0;
        return key;
    endfunction

    function logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    // Receiver side: random stalls on m_axis_tready
    initial begin
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Hold tvalid from the last accepted word unless a gap is drawn
    task automatic send_word(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] wval);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wval, key};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(mode, key, wval);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_limit_readback();
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, ADDR_ENTRY_LIMIT, '0, rdata);
        if (rdata !== PDATA_W'(sb.entry_limit))
            sb.note_mismatch($sformatf("entry_limit readback expected %0d got %0d",
                                       sb.entry_limit, rdata));
    endtask

    task automatic set_entry_limit(input int unsigned limit);
        logic [PDATA_W-1:0] rdata;
        drain();
        apb_access(1'b1, ADDR_ENTRY_LIMIT, PDATA_W'(limit), rdata);
        sb.entry_limit = limit[LIMIT_W-1:0];
        check_limit_readback();
    endtask

    // Empty table, collisions on slot 0, a probe that wraps past the last slot,
    // the reserved key on both operations, and updates while new keys are refused
    task automatic run_directed();
        send_word(MODE_GET, 64'd0, 64'd0);
        send_word(MODE_SET, 64'd0, '1);
        send_word(MODE_GET, 64'd0, 64'd0);
        send_word(MODE_SET, 64'd0, 64'd0);
        send_word(MODE_GET, 64'd0, '1);
        send_word(MODE_SET, 64'd1024, 64'hA5A5_5A5A_0F0F_F0F0);
        send_word(MODE_GET, 64'd1024, 64'hDEAD_BEEF_0000_1111);
        send_word(MODE_SET, 64'd1023, 64'h0123_4567_89AB_CDEF);
        send_word(MODE_SET, 64'd2047, 64'hFEDC_BA98_7654_3210);
        send_word(MODE_GET, 64'd2047, 64'd0);
        send_word(MODE_GET, 64'd3071, 64'd0);
        send_word(MODE_GET, EMPTY_KEY, 64'd0);
        send_word(MODE_SET, EMPTY_KEY, '1);
        send_word(MODE_SET, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001);
        send_word(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0);
        send_word(MODE_SET, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        send_word(MODE_GET, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
        // zero limit: refuse new keys, keep updating old ones
        set_entry_limit(0);
        send_word(MODE_SET, 64'd5, 64'd77);
        send_word(MODE_SET, 64'd0, 64'hC3C3_C3C3_C3C3_C3C3);
        send_word(MODE_GET, 64'd0, 64'd0);
        send_word(MODE_GET, 64'd5, 64'd0);
    endtask

    task automatic run_phase(input int unsigned limit, input int unsigned items);
        logic             mode;
        logic [KEY_W-1:0] key;
        int               r;
        set_entry_limit(limit);
        for (int i = 0; i < items; i++) begin
            if (i == items / 2) begin
                quiet = 1'b0;
                drain();
            end
            quiet = (i >= items / 4) && (i < items / 2);
            r     = $urandom_range(0, 99);
            mode  = ($urandom_range(0, 99) < 60) ? MODE_SET : MODE_GET;
            if (r < 3) begin
                key = EMPTY_KEY;
            end else if (r < 38 && key_pool.size() > 0) begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else begin
                key = fresh_key();
                if (mode == MODE_SET)
                    key_pool.push_back(key);
            end
            send_word(mode, key, pick_value());
        end
        quiet = 1'b0;
    endtask

    // The table never fills every slot: the limit tops out one below the depth
    initial begin
        sb            = new();
        quiet         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_GET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_limit_readback();
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(phase_limit[p], phase_items[p]);

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.pending() > 0)
            sb.note_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
        if (sb.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
src/lpht_pkg.sv
src/lpht_store.sv
src/linear_probe_hash_table_top.sv
dv/tb_linear_probe_hash_table_top.sv
